// ----- src/ispp_pkg.sv -----
// package with shared types and constants of the serial imu packet parser
`timescale 1ns / 1ps
`default_nettype none

package ispp_pkg;

    // packet framing
    localparam int          PACKET_LEN  = 11;
    localparam logic [7:0]  HEADER_BYTE = 8'h55;
    localparam logic [7:0]  TYPE_ACCEL  = 8'h51;
    localparam logic [7:0]  TYPE_RATE   = 8'h52;
    localparam logic [7:0]  TYPE_ANGLE  = 8'h53;

    // window fill counter width, holds 0 .. PACKET_LEN-1
    localparam int FILL_W = $clog2(PACKET_LEN);

    // scaling: value = raw * mul >>> shift (floor), result in Q8
    localparam int          MUL_W       = 17;
    localparam logic [16:0] MUL_ACCEL   = 17'd40141;
    localparam logic [16:0] MUL_RATE    = 17'd125;
    localparam logic [16:0] MUL_ANGLE   = 17'd45;
    localparam int          SHIFT_ACCEL = 15;
    localparam int          SHIFT_RATE  = 3;
    localparam int          SHIFT_ANGLE = 5;

    localparam int RAW_W   = 16;
    localparam int PROD_W  = RAW_W + MUL_W + 1;
    localparam int VALUE_W = 20;

    // depth of the packet queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    // one decoded packet waiting for scaling
    typedef struct packed {
        kind_t                    kind;
        logic signed [RAW_W-1:0]  raw_x;
        logic signed [RAW_W-1:0]  raw_y;
        logic signed [RAW_W-1:0]  raw_z;
    } pkt_rec_t;

    // front to queue write request
    typedef struct packed {
        logic     valid;
        pkt_rec_t rec;
    } push_t;

endpackage

`default_nettype wire

// ----- src/ispp_front.sv -----
// front end: byte window, header and checksum test, packet classification
`timescale 1ns / 1ps
`default_nettype none

module ispp_front #(
    parameter int BURST_MAX = 33
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              queue_full,
    output ispp_pkg::push_t        push
);

    localparam int CNT_W = $clog2(BURST_MAX + 1);

    logic [7:0]                      win_reg [ispp_pkg::PACKET_LEN];
    logic [ispp_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;

    logic       accept;
    logic       eval;
    logic       good;
    logic [7:0] sum;
    logic       known;
    ispp_pkg::kind_t kind;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign eval     = (fill_reg == ispp_pkg::FILL_W'(ispp_pkg::PACKET_LEN - 1));

    // 8-bit checksum over the ten held bytes
    always_comb begin
        sum = 8'd0;
        for (int i = 0; i < ispp_pkg::PACKET_LEN - 1; i++) begin
            sum = sum + win_reg[i];
        end
    end

    assign good = (win_reg[0] == ispp_pkg::HEADER_BYTE) && (sum == s_tdata);

    // packet type decode
    always_comb begin
        known = 1'b1;
        kind  = ispp_pkg::KIND_ACCEL;
        unique case (win_reg[1])
            ispp_pkg::TYPE_ACCEL: kind = ispp_pkg::KIND_ACCEL;
            ispp_pkg::TYPE_RATE:  kind = ispp_pkg::KIND_RATE;
            ispp_pkg::TYPE_ANGLE: kind = ispp_pkg::KIND_ANGLE;
            default:              known = 1'b0;
        endcase
    end

    // queue write for a good packet of a known type
    always_comb begin
        push.valid     = accept && eval && good && known;
        push.rec.kind  = kind;
        push.rec.raw_x = {win_reg[3], win_reg[2]};
        push.rec.raw_y = {win_reg[5], win_reg[4]};
        push.rec.raw_z = {win_reg[7], win_reg[6]};
    end

    // fill and burst counter update
    always_comb begin
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            if (!eval) begin
                fill_next = fill_reg + 1'b1;
            end else if (good) begin
                fill_next = '0;
            end
            if (s_tlast || cnt_reg == CNT_W'(BURST_MAX - 1)) begin
                fill_next = '0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    // window storage: append, or drop the oldest byte on a failed test
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!eval) begin
                win_reg[fill_reg] <= s_tdata;
            end else if (!good) begin
                for (int i = 0; i < ispp_pkg::PACKET_LEN - 2; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[ispp_pkg::PACKET_LEN-2] <= s_tdata;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= ispp_pkg::FILL_W'(ispp_pkg::PACKET_LEN - 1))
        else $error("window fill out of range");
    a_burst_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> fill_reg == '0 && cnt_reg == '0)
        else $error("window not cleared at burst end");
`endif

endmodule

`default_nettype wire

// ----- src/ispp_fifo.sv -----
// short queue of decoded packets between front and back
`timescale 1ns / 1ps
`default_nettype none

module ispp_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ispp_pkg::push_t    push,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output ispp_pkg::pkt_rec_t      head
);

    localparam int PTR_W = $clog2(ispp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ispp_pkg::QUEUE_DEPTH + 1);

    ispp_pkg::pkt_rec_t   slot_reg [ispp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_reg, rd_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(ispp_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_reg];

    // pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_W'(ispp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_W'(ispp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // slot write
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push.rec;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.valid && full))
        else $error("write into full packet queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("read from empty packet queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on write");
`endif

endmodule

`default_nettype wire

// ----- src/ispp_back.sv -----
// back end: constant scaling pipeline and output register
`timescale 1ns / 1ps
`default_nettype none

module ispp_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                empty,
    output logic                     pop,
    input  wire ispp_pkg::pkt_rec_t  head,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [1:0]               m_kind,
    output logic [ispp_pkg::VALUE_W-1:0] m_x,
    output logic [ispp_pkg::VALUE_W-1:0] m_y,
    output logic [ispp_pkg::VALUE_W-1:0] m_z
);

    localparam int PW = ispp_pkg::PROD_W;
    localparam int VW = ispp_pkg::VALUE_W;

    logic                    s1_valid_reg, s1_valid_next;
    ispp_pkg::kind_t         s1_kind_reg;
    logic signed [PW-1:0]    s1_px_reg, s1_py_reg, s1_pz_reg;

    logic                    m_valid_reg, m_valid_next;
    ispp_pkg::kind_t         m_kind_reg;
    logic [VW-1:0]           m_x_reg, m_y_reg, m_z_reg;

    logic                    out_free, s1_move, s1_free;
    logic signed [ispp_pkg::MUL_W:0] mul_xy, mul_z;
    logic signed [PW-1:0]    sx, sy, sz;

    // handshake through the two stages
    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pop      = !empty && s1_free;

    assign s1_valid_next = pop ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = s1_move ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // multiplier constant per packet kind, z forced to zero for angular rate
    always_comb begin
        mul_xy = '0;
        mul_z  = '0;
        unique case (head.kind)
            ispp_pkg::KIND_ACCEL: begin
                mul_xy = $signed({1'b0, ispp_pkg::MUL_ACCEL});
                mul_z  = $signed({1'b0, ispp_pkg::MUL_ACCEL});
            end
            ispp_pkg::KIND_RATE: begin
                mul_xy = $signed({1'b0, ispp_pkg::MUL_RATE});
                mul_z  = '0;
            end
            ispp_pkg::KIND_ANGLE: begin
                mul_xy = $signed({1'b0, ispp_pkg::MUL_ANGLE});
                mul_z  = $signed({1'b0, ispp_pkg::MUL_ANGLE});
            end
            default: begin
                mul_xy = '0;
                mul_z  = '0;
            end
        endcase
    end

    // floor shift per kind
    always_comb begin
        sx = '0;
        sy = '0;
        sz = '0;
        unique case (s1_kind_reg)
            ispp_pkg::KIND_ACCEL: begin
                sx = s1_px_reg >>> ispp_pkg::SHIFT_ACCEL;
                sy = s1_py_reg >>> ispp_pkg::SHIFT_ACCEL;
                sz = s1_pz_reg >>> ispp_pkg::SHIFT_ACCEL;
            end
            ispp_pkg::KIND_RATE: begin
                sx = s1_px_reg >>> ispp_pkg::SHIFT_RATE;
                sy = s1_py_reg >>> ispp_pkg::SHIFT_RATE;
                sz = s1_pz_reg >>> ispp_pkg::SHIFT_RATE;
            end
            ispp_pkg::KIND_ANGLE: begin
                sx = s1_px_reg >>> ispp_pkg::SHIFT_ANGLE;
                sy = s1_py_reg >>> ispp_pkg::SHIFT_ANGLE;
                sz = s1_pz_reg >>> ispp_pkg::SHIFT_ANGLE;
            end
            default: begin
                sx = '0;
                sy = '0;
                sz = '0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_kind_reg <= head.kind;
            s1_px_reg   <= PW'(head.raw_x * mul_xy);
            s1_py_reg   <= PW'(head.raw_y * mul_xy);
            s1_pz_reg   <= PW'(head.raw_z * mul_z);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_kind_reg <= s1_kind_reg;
            m_x_reg    <= sx[VW-1:0];
            m_y_reg    <= sy[VW-1:0];
            m_z_reg    <= sz[VW-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_x      = m_x_reg;
    assign m_y      = m_y_reg;
    assign m_z      = m_z_reg;

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_px_reg))
        else $error("product stage lost data while stalled");
`endif

endmodule

`default_nettype wire

// ----- src/imu_serial_packet_parser.sv -----
// top level of the serial imu packet parser
// path: a completed packet passes the queue, the product stage and the output register
// throughput: one input beat per cycle; the front stalls only when the 4-entry
//   packet queue is full, which happens when the result side holds back
// reset: synchronous active-low aresetn clears window fill, burst count, queue
//   and output valid; window bytes are rewritten before use and need no reset
`timescale 1ns / 1ps
`default_nettype none

module imu_serial_packet_parser #(
    parameter int BURST_MAX = 33
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // burst_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [19:0] value_x, [39:20] value_y, [59:40] value_z
    output logic [1:0]       m_tuser    // [1:0] pkt_kind
);

    ispp_pkg::push_t     push;
    ispp_pkg::pkt_rec_t  head;
    logic                q_full, q_empty, q_pop;
    logic [ispp_pkg::VALUE_W-1:0] vx, vy, vz;

    // window and classification
    ispp_front #(
        .BURST_MAX (BURST_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (q_full),
        .push       (push)
    );

    // packet queue
    ispp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .empty   (q_empty),
        .pop     (q_pop),
        .head    (head)
    );

    // scaling and output
    ispp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (q_empty),
        .pop      (q_pop),
        .head     (head),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_kind   (m_tuser),
        .m_x      (vx),
        .m_y      (vy),
        .m_z      (vz)
    );

    assign m_tdata = {4'd0, vz, vy, vx};

endmodule

`default_nettype wire
